>>> hdl/apst_pkg.sv
`default_nettype none

package apst_pkg;

  // Command codes of a request transaction.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Register byte offsets.
  localparam logic [11:0] OFF_TPR  = 12'h080;
  localparam logic [11:0] OFF_EOI  = 12'h0B0;
  localparam logic [11:0] OFF_SVR  = 12'h0F0;
  localparam logic [11:0] OFF_LVT  = 12'h320;
  localparam logic [11:0] OFF_INIT = 12'h380;
  localparam logic [11:0] OFF_CUR  = 12'h390;
  localparam logic [11:0] OFF_DIV  = 12'h3E0;

  // LVT timer bit positions.
  localparam int unsigned LVT_MASK_POS     = 16;
  localparam int unsigned LVT_PERIODIC_POS = 17;
  // Software enable bit of the spurious vector register.
  localparam int unsigned SVR_ENABLE_POS   = 8;

  localparam logic [8:0]  SVR_RESET = 9'h0FF;
  localparam logic [17:0] LVT_RESET = 18'h10000;

  // Divisor for the divide configuration code {bit3, bit1, bit0}.
  // Code 7 divides by one; others give 2, 4, ... 128.
  function automatic logic [7:0] divisor_of(input logic [3:0] code);
    logic [2:0] sel;
    sel = {code[3], code[1:0]};
    if (sel == 3'd7) begin
      divisor_of = 8'd1;
    end else begin
      divisor_of = 8'd2 << sel;
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/apst_if.sv
`default_nettype none

// Request channel: one register access or one timer tick per transaction.
interface apst_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [11:0] reg_offset;
  logic [31:0] write_data;

  modport source (output valid, output command, output reg_offset, output write_data,
                  input ready);
  modport sink (input valid, input command, input reg_offset, input write_data,
                output ready);
endinterface

// Response channel: one result per request transaction.
interface apst_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_valid;
  logic [7:0]  irq_vector;

  modport source (output valid, output read_data, output irq_valid, output irq_vector,
                  input ready);
  modport sink (input valid, input read_data, input irq_valid, input irq_vector,
                output ready);
endinterface

`default_nettype wire

>>> hdl/apic_style_periodic_timer.sv
// Local-APIC-style timer with a valid/ready request and response channel.
// Each request transaction is a register read, a register write, or one
// input clock tick. Every request produces exactly one response transaction
// carrying the read data (zero unless a read) and any interrupt delivered.
// A request is captured into an input register; once the output register
// is free, the register file and counters are updated and the response is
// loaded into the output register, from which it is offered. While the
// receiver keeps ready high, one request can be accepted every cycle.
// The rate is set by the single update path between the input register and
// the output register, which handles one transaction per cycle unless stalled.
// When the receiver stalls, the output register holds its response, the
// input register holds the next request, and ready drops once both are
// full; nothing is lost or repeated. Reset (rst_ni low, asynchronous) empties
// both stages and returns the registers to their defaults: software
// disabled, timer masked and one-shot, all counts zero, divide by two.
`default_nettype none

module apic_style_periodic_timer (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  apst_req_if.sink    req_i,
  apst_rsp_if.source  rsp_o
);

  // Input register stage.
  logic        s1_valid_q;
  logic [1:0]  s1_cmd_q;
  logic [11:0] s1_off_q;
  logic [31:0] s1_data_q;

  // Output register stage.
  logic        out_valid_q;
  logic [31:0] out_rdata_q, out_rdata_d;
  logic        out_irq_q, out_irq_d;
  logic [7:0]  out_vec_q, out_vec_d;

  // Architectural state.
  logic [7:0]  tpr_q, tpr_d;
  logic [8:0]  svr_q, svr_d;
  logic [17:0] lvt_q, lvt_d;
  logic [31:0] init_q, init_d;
  logic [31:0] cur_q, cur_d;
  logic [3:0]  div_q, div_d;
  logic [6:0]  pre_q, pre_d;
  logic        insvc_q, insvc_d;
  logic        pend_q, pend_d;

  logic        out_free;
  logic        s1_fire;
  logic        in_fire;
  logic [31:0] cur_dec;
  logic [7:0]  pre_inc;

  // The update stage moves whenever the output register is empty or drained.
  assign out_free      = !out_valid_q || rsp_o.ready;
  assign s1_fire       = s1_valid_q && out_free;
  assign req_i.ready   = !s1_valid_q || out_free;
  assign in_fire       = req_i.valid && req_i.ready;

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_data  = out_rdata_q;
  assign rsp_o.irq_valid  = out_irq_q;
  assign rsp_o.irq_vector = out_vec_q;

  assign cur_dec = cur_q - 32'd1;
  assign pre_inc = {1'b0, pre_q} + 8'd1;

  always_comb begin
    tpr_d       = tpr_q;
    svr_d       = svr_q;
    lvt_d       = lvt_q;
    init_d      = init_q;
    cur_d       = cur_q;
    div_d       = div_q;
    pre_d       = pre_q;
    insvc_d     = insvc_q;
    pend_d      = pend_q;
    out_rdata_d = 32'd0;
    out_irq_d   = 1'b0;

    case (s1_cmd_q)
      apst_pkg::CMD_READ: begin
        case (s1_off_q)
          apst_pkg::OFF_TPR:  out_rdata_d = {24'd0, tpr_q};
          apst_pkg::OFF_SVR:  out_rdata_d = {23'd0, svr_q};
          apst_pkg::OFF_LVT:  out_rdata_d = {14'd0, lvt_q};
          apst_pkg::OFF_INIT: out_rdata_d = init_q;
          apst_pkg::OFF_CUR:  out_rdata_d = cur_q;
          apst_pkg::OFF_DIV:  out_rdata_d = {28'd0, div_q};
          default:            out_rdata_d = 32'd0;
        endcase
      end
      apst_pkg::CMD_WRITE: begin
        case (s1_off_q)
          apst_pkg::OFF_TPR: tpr_d = s1_data_q[7:0];
          apst_pkg::OFF_SVR: svr_d = s1_data_q[8:0];
          apst_pkg::OFF_LVT: lvt_d = {s1_data_q[17:16], 8'd0, s1_data_q[7:0]};
          apst_pkg::OFF_INIT: begin
            init_d = s1_data_q;
            cur_d  = s1_data_q;
            pre_d  = 7'd0;
          end
          apst_pkg::OFF_DIV: div_d = {s1_data_q[3], 1'b0, s1_data_q[1:0]};
          apst_pkg::OFF_EOI: begin
            // A waiting expiry goes out on the EOI itself and stays in service.
            if (insvc_q) begin
              if (pend_q) begin
                pend_d    = 1'b0;
                out_irq_d = 1'b1;
              end else begin
                insvc_d = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      apst_pkg::CMD_TICK: begin
        if (cur_q != 32'd0) begin
          if (pre_inc >= apst_pkg::divisor_of(div_q)) begin
            pre_d = 7'd0;
            cur_d = cur_dec;
            if (cur_dec == 32'd0) begin
              if (lvt_q[apst_pkg::LVT_PERIODIC_POS]) begin
                cur_d = init_q;
              end
              if (!lvt_q[apst_pkg::LVT_MASK_POS] && svr_q[apst_pkg::SVR_ENABLE_POS]) begin
                if (!insvc_q) begin
                  insvc_d   = 1'b1;
                  out_irq_d = 1'b1;
                end else begin
                  pend_d = 1'b1;
                end
              end
            end
          end else begin
            pre_d = pre_inc[6:0];
          end
        end
      end
      default: ;
    endcase

    out_vec_d = out_irq_d ? lvt_d[7:0] : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tpr_q       <= 8'd0;
      svr_q       <= apst_pkg::SVR_RESET;
      lvt_q       <= apst_pkg::LVT_RESET;
      init_q      <= 32'd0;
      cur_q       <= 32'd0;
      div_q       <= 4'd0;
      pre_q       <= 7'd0;
      insvc_q     <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        tpr_q   <= tpr_d;
        svr_q   <= svr_d;
        lvt_q   <= lvt_d;
        init_q  <= init_d;
        cur_q   <= cur_d;
        div_q   <= div_d;
        pre_q   <= pre_d;
        insvc_q <= insvc_d;
        pend_q  <= pend_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q  <= req_i.command;
      s1_off_q  <= req_i.reg_offset;
      s1_data_q <= req_i.write_data;
    end
    if (s1_fire) begin
      out_rdata_q <= out_rdata_d;
      out_irq_q   <= out_irq_d;
      out_vec_q   <= out_vec_d;
    end
  end

  // An expiry can only wait while another interrupt is in service.
  a_pend_needs_insvc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> insvc_q)
    else $error("expiry pending with nothing in service");

  // A delivered interrupt still waiting in the output register is in service.
  a_irq_in_service: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_irq_q) |-> insvc_q)
    else $error("interrupt offered while not in service");

  // No vector is reported without an interrupt.
  a_vec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_irq_q) |-> (out_vec_q == 8'd0))
    else $error("vector reported without interrupt");

  // The counter changes only when a transaction passes the update stage.
  a_count_moves_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cur_q) |-> $past(s1_fire))
    else $error("current count changed without a transaction");

endmodule

`default_nettype wire

>>> test/tb_apic_style_periodic_timer.sv
// Testbench for the local-APIC-style timer. A directed table runs first: it
// covers reset values, register extremes and the corner cases of the timer.
// A long random run follows. It is mostly clock ticks with small counts, so
// interrupts, periodic reloads, waiting expiries and EOI deliveries all occur
// often. Every accepted response transaction is checked field by field
// against the typed-in answer of a row or a behavioral timer model in this module.
module tb_apic_style_periodic_timer;

  // Command 3 is not a defined operation. The timer must answer it with an
  // all-zero response and leave its state alone.
  localparam logic [1:0]  CMD_NONE     = 2'd3;
  localparam logic [11:0] OFF_UNMAPPED = 12'hFFF;

  // Bits that each register keeps on a write.
  localparam logic [8:0]  SVR_KEEP = 9'h1FF;
  localparam logic [17:0] LVT_KEEP = 18'h300FF;
  localparam logic [3:0]  DIV_KEEP = 4'hB;

  localparam int unsigned HALF_PERIOD    = 6;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned IDLE_PERCENT   = 38;
  localparam int unsigned RANDOM_ITEMS   = 1000;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned DRAIN_CYCLES   = 8;
  // Cycles with no transaction on either channel before the run is abandoned.
  // The slowest correct stretch is the long receiver hold-off, so this leaves
  // a wide margin.
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  localparam int unsigned NUM_DIRECTED = 27;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_valid;
    logic [7:0]  irq_vector;
  } timer_rsp_t;

  // One row of the directed table. Where fixed is set, rsp is the response
  // that the row must produce. Otherwise the model decides it.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] off;
    logic [31:0] data;
    logic        fixed;
    timer_rsp_t  rsp;
  } stim_row_t;

  localparam timer_rsp_t ZERO_RSP = '0;

  logic clk_i;
  logic rst_ni;

  apst_req_if req_bus ();
  apst_rsp_if rsp_bus ();

  apic_style_periodic_timer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Model state of the timer, updated once for each accepted request.
  logic [7:0]  tpr_q;
  logic [8:0]  svr_q;
  logic [17:0] lvt_q;
  logic [31:0] init_count_q;
  logic [31:0] cur_count_q;
  logic [3:0]  div_code_q;
  logic [6:0]  prescale_q;
  logic        in_service_q;
  logic        expiry_waiting_q;

  // Responses still owed by the timer, oldest first.
  timer_rsp_t awaited_responses[$];

  // The row currently offered, so that the request monitor knows whether a
  // typed-in response overrides the model.
  logic       row_fixed;
  timer_rsp_t row_fixed_rsp;

  logic sender_idling;
  logic receiver_idling;
  int unsigned hold_offs_requested;
  int unsigned hold_offs_done;

  int unsigned fail_count;
  int unsigned n_reads, n_writes, n_ticks, n_others, n_irqs, n_checked;

  stim_row_t directed_rows [0:NUM_DIRECTED-1];

  // Offsets that hit a register, used to steer random reads and writes.
  logic [11:0] mapped_offsets [0:6];

  always #HALF_PERIOD clk_i = ~clk_i;

  // Behavioral model of one request transaction. It updates the model state
  // and returns the response that the timer must give.
  function automatic timer_rsp_t predict_timer_response(input logic [1:0] cmd,
                                                        input logic [11:0] off,
                                                        input logic [31:0] data);
    timer_rsp_t  r;
    logic [2:0]  sel;
    int unsigned ratio;
    r = '0;
    case (cmd)
      apst_pkg::CMD_READ: begin
        case (off)
          apst_pkg::OFF_TPR:  r.read_data = {24'd0, tpr_q};
          apst_pkg::OFF_SVR:  r.read_data = {23'd0, svr_q};
          apst_pkg::OFF_LVT:  r.read_data = {14'd0, lvt_q};
          apst_pkg::OFF_INIT: r.read_data = init_count_q;
          apst_pkg::OFF_CUR:  r.read_data = cur_count_q;
          apst_pkg::OFF_DIV:  r.read_data = {28'd0, div_code_q};
          default:            r.read_data = '0;
        endcase
      end
      apst_pkg::CMD_WRITE: begin
        case (off)
          apst_pkg::OFF_TPR: tpr_q = data[7:0];
          apst_pkg::OFF_SVR: svr_q = data[8:0] & SVR_KEEP;
          apst_pkg::OFF_LVT: lvt_q = data[17:0] & LVT_KEEP;
          apst_pkg::OFF_INIT: begin
            // Loading the initial count restarts the countdown from scratch.
            init_count_q = data;
            cur_count_q  = data;
            prescale_q   = '0;
          end
          apst_pkg::OFF_DIV: div_code_q = data[3:0] & DIV_KEEP;
          apst_pkg::OFF_EOI: begin
            // An EOI ends the current service. A waiting expiry is handed
            // over at once, with the vector the LVT holds right now.
            if (in_service_q) begin
              in_service_q = 1'b0;
              if (expiry_waiting_q) begin
                expiry_waiting_q = 1'b0;
                in_service_q     = 1'b1;
                r.irq_valid      = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      apst_pkg::CMD_TICK: begin
        // A stopped timer ignores ticks and its prescaler holds.
        if (cur_count_q != '0) begin
          sel   = {div_code_q[3], div_code_q[1:0]};
          ratio = (sel == 3'd7) ? 1 : (2 << sel);
          // A prescaler already at or past the end of a shorter period, after
          // a divide change, finishes the period on this tick.
          if (int'(prescale_q) + 1 >= ratio) begin
            prescale_q  = '0;
            cur_count_q = cur_count_q - 32'd1;
            if (cur_count_q == '0) begin
              if (lvt_q[apst_pkg::LVT_PERIODIC_POS]) begin
                cur_count_q = init_count_q;
              end
              // Masked or software-disabled expiries are simply lost. With one
              // interrupt in service, a single further expiry may wait.
              if (!lvt_q[apst_pkg::LVT_MASK_POS] && svr_q[apst_pkg::SVR_ENABLE_POS]) begin
                if (!in_service_q) begin
                  in_service_q = 1'b1;
                  r.irq_valid  = 1'b1;
                end else begin
                  expiry_waiting_q = 1'b1;
                end
              end
            end
          end else begin
            prescale_q = prescale_q + 7'd1;
          end
        end
      end
      default: ;
    endcase
    if (r.irq_valid) begin
      r.irq_vector = lvt_q[7:0];
    end
    return r;
  endfunction

  // Offers one request transaction, with random idle cycles ahead of it, and
  // returns at the falling edge after the timer has taken it.
  task automatic offer_request(input logic [1:0] cmd, input logic [11:0] off,
                               input logic [31:0] data, input logic fixed,
                               input timer_rsp_t fixed_rsp);
    while (sender_idling && $urandom_range(0, 99) < IDLE_PERCENT) begin
      req_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    req_bus.command    = cmd;
    req_bus.reg_offset = off;
    req_bus.write_data = data;
    row_fixed          = fixed;
    row_fixed_rsp      = fixed_rsp;
    req_bus.valid      = 1'b1;
    do @(posedge clk_i); while (!req_bus.ready);
    @(negedge clk_i);
  endtask

  // Request and response monitor. The request side runs the model and files
  // the expectation, and the response side checks against the oldest one.
  always @(posedge clk_i) begin : monitor
    timer_rsp_t predicted;
    timer_rsp_t awaited;
    if (rst_ni) begin
      if (req_bus.valid && req_bus.ready) begin
        predicted = predict_timer_response(req_bus.command, req_bus.reg_offset,
                                           req_bus.write_data);
        awaited_responses.push_back(row_fixed ? row_fixed_rsp : predicted);
        case (req_bus.command)
          apst_pkg::CMD_READ:  n_reads++;
          apst_pkg::CMD_WRITE: n_writes++;
          apst_pkg::CMD_TICK:  n_ticks++;
          default:             n_others++;
        endcase
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        n_checked++;
        if (rsp_bus.irq_valid === 1'b1) begin
          n_irqs++;
        end
        if (awaited_responses.size() == 0) begin
          $error("response transaction with no request outstanding");
          fail_count++;
        end else begin
          awaited = awaited_responses.pop_front();
          if (rsp_bus.read_data !== awaited.read_data) begin
            $error("read_data: expected %h, got %h", awaited.read_data, rsp_bus.read_data);
            fail_count++;
          end
          if (rsp_bus.irq_valid !== awaited.irq_valid) begin
            $error("irq_valid: expected %b, got %b", awaited.irq_valid, rsp_bus.irq_valid);
            fail_count++;
          end
          if (rsp_bus.irq_vector !== awaited.irq_vector) begin
            $error("irq_vector: expected %h, got %h", awaited.irq_vector,
                   rsp_bus.irq_vector);
            fail_count++;
          end
        end
      end
    end
  end

  // Receiver. It stalls at random while receiver_idling is set. When the
  // sender asks for a hold-off, it keeps ready low for a long stretch that it
  // counts itself, so that both pipeline stages fill and the request side
  // backs up.
  initial begin
    rsp_bus.ready  = 1'b0;
    hold_offs_done = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_offs_done != hold_offs_requested) begin
        rsp_bus.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
        hold_offs_done++;
      end else begin
        rsp_bus.ready = !receiver_idling || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog. It counts cycles in which neither channel completes a
  // transaction and gives up on the run once the count reaches the limit.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_ni);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("apic_style_periodic_timer regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned pick;
    logic [1:0]  cmd;
    logic [11:0] off;
    logic [31:0] data;

    clk_i  = 1'b0;
    rst_ni = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.command    = apst_pkg::CMD_READ;
    req_bus.reg_offset = '0;
    req_bus.write_data = '0;
    row_fixed          = 1'b0;
    row_fixed_rsp      = ZERO_RSP;
    sender_idling      = 1'b1;
    receiver_idling    = 1'b1;
    hold_offs_requested = 0;
    fail_count = 0;
    n_reads = 0;
    n_writes = 0;
    n_ticks = 0;
    n_others = 0;
    n_irqs = 0;
    n_checked = 0;

    // Model state after reset: software disabled, timer masked and one-shot,
    // counts zero, divide by two.
    tpr_q            = '0;
    svr_q            = apst_pkg::SVR_RESET;
    lvt_q            = apst_pkg::LVT_RESET;
    init_count_q     = '0;
    cur_count_q      = '0;
    div_code_q       = '0;
    prescale_q       = '0;
    in_service_q     = 1'b0;
    expiry_waiting_q = 1'b0;

    mapped_offsets = '{apst_pkg::OFF_TPR, apst_pkg::OFF_EOI, apst_pkg::OFF_SVR,
                       apst_pkg::OFF_LVT, apst_pkg::OFF_INIT, apst_pkg::OFF_CUR,
                       apst_pkg::OFF_DIV};

    // Directed rows. The first block checks reset values and register
    // extremes with typed-in answers. The rest walks one periodic countdown
    // through delivery, a waiting expiry and its EOI handover, then a divide
    // change that cuts a prescale period short.
    directed_rows = '{
      '{apst_pkg::CMD_READ, apst_pkg::OFF_SVR, 32'h0, 1'b1, '{32'h0FF, 1'b0, 8'h00}},
      '{apst_pkg::CMD_READ, OFF_UNMAPPED, 32'hFFFFFFFF, 1'b1, ZERO_RSP},
      '{CMD_NONE, OFF_UNMAPPED, 32'hFFFFFFFF, 1'b1, ZERO_RSP},
      // A tick with the count at zero does nothing.
      '{apst_pkg::CMD_TICK, apst_pkg::OFF_TPR, 32'h0, 1'b1, ZERO_RSP},
      '{apst_pkg::CMD_WRITE, apst_pkg::OFF_TPR, 32'hFFFFFFFF, 1'b1, ZERO_RSP},
      '{apst_pkg::CMD_WRITE, apst_pkg::OFF_SVR, 32'hFFFFFFFF, 1'b1, ZERO_RSP},
      '{apst_pkg::CMD_READ, apst_pkg::OFF_SVR, 32'h0, 1'b1, '{32'h1FF, 1'b0, 8'h00}},
      '{apst_pkg::CMD_WRITE, apst_pkg::OFF_LVT, 32'hFFFFFFFF, 1'b1, ZERO_RSP},
      '{apst_pkg::CMD_READ, apst_pkg::OFF_LVT, 32'h0, 1'b1, '{32'h300FF, 1'b0, 8'h00}},
      '{apst_pkg::CMD_WRITE, apst_pkg::OFF_DIV, 32'hFFFFFFFF, 1'b1, ZERO_RSP},
      '{apst_pkg::CMD_READ, apst_pkg::OFF_DIV, 32'h0, 1'b1, '{32'hB, 1'b0, 8'h00}},
      '{apst_pkg::CMD_WRITE, apst_pkg::OFF_INIT, 32'hFFFFFFFF, 1'b1, ZERO_RSP},
      '{apst_pkg::CMD_READ, apst_pkg::OFF_INIT, 32'h0, 1'b1,
        '{32'hFFFFFFFF, 1'b0, 8'h00}},
      // Periodic, unmasked, vector A5, divide by one, count of two.
      '{apst_pkg::CMD_WRITE, apst_pkg::OFF_LVT, 32'h000200A5, 1'b0, ZERO_RSP},
      '{apst_pkg::CMD_WRITE, apst_pkg::OFF_INIT, 32'h2, 1'b0, ZERO_RSP},
      '{apst_pkg::CMD_TICK, apst_pkg::OFF_TPR, 32'h0, 1'b0, ZERO_RSP},
      '{apst_pkg::CMD_TICK, apst_pkg::OFF_TPR, 32'h0, 1'b0, ZERO_RSP},
      '{apst_pkg::CMD_TICK, apst_pkg::OFF_TPR, 32'h0, 1'b0, ZERO_RSP},
      '{apst_pkg::CMD_TICK, apst_pkg::OFF_TPR, 32'h0, 1'b0, ZERO_RSP},
      // Hand over the waiting expiry, end its service, then an EOI with
      // nothing in service.
      '{apst_pkg::CMD_WRITE, apst_pkg::OFF_EOI, 32'h0, 1'b0, ZERO_RSP},
      '{apst_pkg::CMD_WRITE, apst_pkg::OFF_EOI, 32'h0, 1'b0, ZERO_RSP},
      '{apst_pkg::CMD_WRITE, apst_pkg::OFF_EOI, 32'h0, 1'b0, ZERO_RSP},
      // Divide by four, one tick in, then switch to divide by two; the next
      // tick ends the period.
      '{apst_pkg::CMD_WRITE, apst_pkg::OFF_DIV, 32'h1, 1'b0, ZERO_RSP},
      '{apst_pkg::CMD_WRITE, apst_pkg::OFF_INIT, 32'h3, 1'b0, ZERO_RSP},
      '{apst_pkg::CMD_TICK, apst_pkg::OFF_TPR, 32'h0, 1'b0, ZERO_RSP},
      '{apst_pkg::CMD_WRITE, apst_pkg::OFF_DIV, 32'h0, 1'b0, ZERO_RSP},
      '{apst_pkg::CMD_TICK, apst_pkg::OFF_TPR, 32'h0, 1'b0, ZERO_RSP}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer_request(directed_rows[i].cmd, directed_rows[i].off, directed_rows[i].data,
                    directed_rows[i].fixed, directed_rows[i].rsp);
    end

    // Random part. Most transactions are ticks, and most counts and divide
    // codes are small, so that timers expire often. Writes carry full random data
    // apart from enable, mask, divide and count fields steered into useful states.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // Long hold-off by the receiver while requests keep coming.
      if (i == 300) begin
        hold_offs_requested++;
      end
      // The sender waits until every response is in.
      if (i == 600) begin
        req_bus.valid = 1'b0;
        while (awaited_responses.size() != 0) @(negedge clk_i);
      end
      // A stretch at full rate on both sides.
      sender_idling   = !(i >= 650 && i < 800);
      receiver_idling = sender_idling;

      pick = $urandom_range(0, 99);
      data = $urandom;
      off  = 12'($urandom);
      if (pick < 55) begin
        cmd = apst_pkg::CMD_TICK;
      end else if (pick < 65) begin
        cmd = apst_pkg::CMD_READ;
        if ($urandom_range(0, 9) < 7) begin
          off = mapped_offsets[$urandom_range(0, 6)];
        end
      end else if (pick < 88) begin
        cmd = apst_pkg::CMD_WRITE;
        off = mapped_offsets[$urandom_range(0, 6)];
        case (off)
          apst_pkg::OFF_SVR: begin
            if ($urandom_range(0, 4) != 0) data[apst_pkg::SVR_ENABLE_POS] = 1'b1;
          end
          apst_pkg::OFF_LVT: begin
            if ($urandom_range(0, 4) != 0) data[apst_pkg::LVT_MASK_POS] = 1'b0;
          end
          apst_pkg::OFF_INIT: begin
            pick = $urandom_range(0, 19);
            if (pick < 17) begin
              data = $urandom_range(1, 12);
            end else if (pick < 19) begin
              data = '0;
            end
          end
          apst_pkg::OFF_DIV: begin
            // Mostly divide by one, two or four; otherwise any code.
            case ($urandom_range(0, 4))
              0: data[3:0] = 4'b1011;
              1: data[3:0] = 4'b0000;
              2: data[3:0] = 4'b0001;
              default: ;
            endcase
          end
          default: ;
        endcase
      end else if (pick < 96) begin
        cmd = apst_pkg::CMD_WRITE;
        off = apst_pkg::OFF_EOI;
      end else if (pick < 98) begin
        cmd = apst_pkg::CMD_WRITE;
      end else begin
        cmd = CMD_NONE;
      end
      offer_request(cmd, off, data, 1'b0, ZERO_RSP);
    end

    req_bus.valid = 1'b0;
    sender_idling = 1'b1;
    while (awaited_responses.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d transactions: %0d reads, %0d writes, %0d ticks, %0d undefined",
             n_checked, n_reads, n_writes, n_ticks, n_others);
    $display("%0d interrupts delivered, with a long receiver hold-off and a drain pause",
             n_irqs);
    if (fail_count == 0) begin
      $display("apic_style_periodic_timer regression: pass");
    end else begin
      $display("apic_style_periodic_timer regression: fail");
    end
    $finish;
  end

endmodule
